@@ hw/rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int NFRAMES_DEF = 64;
    localparam int FRAME_W     = 6;
    localparam int PAGE_W      = 16;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_UNLOCK  = 2'd2,
        CMD_ACCESS  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NOVICTIM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SWEEP,
        S_VICTIM,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/page_frame_allocator_clock.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_clock
// frame allocator with free stack and clock sweep replacement
// ----------------------------------------------------------------------------
// sequence: start is taken in idle, then the read, exec and done states for
//   release, unlock, access and allocate from the stack; an allocate with an
//   empty stack passes through sweep, and through victim if a victim is found
// throughput: one command at a time; busy drops in the cycle of the result
//   transfer
// reset: synchronous active low; flags reset directly, stack seeded lazily by
//   its fill mark, no clearing pass; the receiver cannot stall
module page_frame_allocator_clock
    import pfa_pkg::*;
#(
    parameter int NFRAMES = NFRAMES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_command,
    input  logic [FRAME_W-1:0]   i_frame,
    input  logic [PAGE_W-1:0]    i_virtual_page,
    input  logic                 i_is_write,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [FRAME_W-1:0]   o_granted_frame,
    output logic                 o_unmapped_valid,
    output logic [PAGE_W-1:0]    o_unmapped_page,
    output logic                 o_writeback_needed
);

    localparam int IW = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
    localparam int CW = $clog2(NFRAMES + 1);
    localparam int SW = $clog2(2 * NFRAMES + 1);

    // flags per frame
    logic [NFRAMES-1:0] r_free, r_lock, r_ref, r_dirty;
    // stack: entries at positions below the low watermark untouched since reset
    logic [IW-1:0]      r_stack [NFRAMES];
    logic [PAGE_W-1:0]  r_page  [NFRAMES];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_seed;   // positions below r_seed never written
    logic [IW-1:0]      r_hand;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [PAGE_W-1:0]  r_vp;
    logic               r_wr;
    logic               r_bad;
    logic [IW-1:0]      r_f;
    logic [IW-1:0]      r_h;
    logic [SW-1:0]      r_n;
    logic [IW-1:0]      r_stk_rd;
    logic [PAGE_W-1:0]  r_page_rd;

    logic [1:0]         r_status;
    logic [FRAME_W-1:0] r_granted;
    logic               r_uv, r_wb, r_done;
    logic [PAGE_W-1:0]  r_up;

    logic [CW-1:0]      w_top;
    logic [IW-1:0]      w_hnext;
    logic [IW-1:0]      w_rd_idx;

    assign busy    = (r_state != S_IDLE);
    assign w_top   = r_count - CW'(1);
    assign w_hnext = (r_h == IW'(NFRAMES - 1)) ? '0 : r_h + IW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC: begin
                if (r_cmd == CMD_ALLOC && r_count == '0) n_state = S_SWEEP;
                else n_state = S_DONE;
            end
            S_SWEEP: begin
                if (r_n == SW'(2 * NFRAMES)) n_state = S_DONE;
                else if (!r_lock[r_h] && !r_ref[r_h]) n_state = S_VICTIM;
            end
            S_VICTIM: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign w_rd_idx = (r_cmd == CMD_ALLOC) ? r_h : r_f;

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_stk_rd  <= (w_top < r_seed) ? (IW'(NFRAMES - 1) - w_top[IW-1:0])
                                      : r_stack[w_top[IW-1:0]];
        r_page_rd <= r_page[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '1;
            r_lock  <= '0;
            r_ref   <= '0;
            r_dirty <= '0;
            r_count <= CW'(NFRAMES);
            r_seed  <= CW'(NFRAMES);
            r_hand  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_cmd   <= t_cmd'(i_command);
                    r_vp    <= i_virtual_page;
                    r_wr    <= i_is_write;
                    r_f     <= IW'(i_frame);
                    r_bad   <= (32'(i_frame) >= NFRAMES);
                    r_h     <= r_hand;
                    r_n     <= '0;
                end
                S_READ: begin
                    if (!r_bad) r_bad <= r_free[r_f];
                end
                S_EXEC: begin
                    r_status  <= ST_OK;
                    r_granted <= '0;
                    r_uv      <= 1'b0;
                    r_up      <= '0;
                    r_wb      <= 1'b0;
                    unique case (r_cmd)
                        CMD_ALLOC: if (r_count != '0) begin
                            r_count <= w_top;
                            if (w_top < r_seed) r_seed <= w_top;
                            r_free[r_stk_rd]  <= 1'b0;
                            r_lock[r_stk_rd]  <= 1'b1;
                            r_ref[r_stk_rd]   <= 1'b0;
                            r_dirty[r_stk_rd] <= 1'b0;
                            r_page[r_stk_rd]  <= r_vp;
                            r_granted <= FRAME_W'(r_stk_rd);
                        end
                        CMD_RELEASE: begin
                            if (r_bad || r_count >= CW'(NFRAMES)) r_status <= ST_BAD;
                            else begin
                                r_free[r_f]  <= 1'b1;
                                r_lock[r_f]  <= 1'b0;
                                r_ref[r_f]   <= 1'b0;
                                r_dirty[r_f] <= 1'b0;
                                r_stack[r_count[IW-1:0]] <= r_f;
                                if (r_count < r_seed) r_seed <= r_count;
                                r_count <= r_count + CW'(1);
                                r_uv <= 1'b1;
                                r_up <= r_page_rd;
                            end
                        end
                        CMD_UNLOCK: begin
                            if (r_bad || !r_lock[r_f]) r_status <= ST_BAD;
                            else r_lock[r_f] <= 1'b0;
                        end
                        CMD_ACCESS: begin
                            if (r_bad) r_status <= ST_BAD;
                            else begin
                                r_ref[r_f] <= 1'b1;
                                if (r_wr) r_dirty[r_f] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SWEEP: begin
                    if (r_n == SW'(2 * NFRAMES)) r_status <= ST_NOVICTIM;
                    else if (!r_lock[r_h] && !r_ref[r_h]) begin
                        r_n <= r_n;
                    end else begin
                        if (!r_lock[r_h]) r_ref[r_h] <= 1'b0;
                        r_h <= w_hnext;
                        r_n <= r_n + SW'(1);
                    end
                end
                S_VICTIM: begin
                    r_uv        <= 1'b1;
                    r_up        <= r_page_rd;
                    r_wb        <= r_dirty[r_h];
                    r_granted   <= FRAME_W'(r_h);
                    r_free[r_h] <= 1'b0;
                    r_lock[r_h] <= 1'b1;
                    r_ref[r_h]  <= 1'b0;
                    r_dirty[r_h]<= 1'b0;
                    r_page[r_h] <= r_vp;
                    r_hand      <= w_hnext;
                end
                S_DONE:  r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_granted_frame    = r_granted;
    assign o_unmapped_valid   = r_uv;
    assign o_unmapped_page    = r_up;
    assign o_writeback_needed = r_wb;

endmodule

@@ hw/rtl/pfa_checker.sv @@
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks of the page frame allocator
// ----------------------------------------------------------------------------
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [1:0]           o_status,
    input logic [FRAME_W-1:0]   o_granted_frame,
    input logic                 o_unmapped_valid,
    input logic                 o_writeback_needed
);

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer not taken");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
        (o_granted_frame == '0 && !o_unmapped_valid && !o_writeback_needed))
        else $error("failed command has side outputs");

    a_wb_uv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_writeback_needed) |-> o_unmapped_valid)
        else $error("writeback without unmap");

endmodule

bind page_frame_allocator_clock pfa_checker u_pfa_checker (.*);

@@ tb/sv/page_frame_allocator_clock_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_clock_test
// drives allocate, release, unlock and access commands into the frame
// allocator, predicts every result with a behavioral copy of the free stack
// and clock sweep, and compares each result strobe field by field
// ----------------------------------------------------------------------------
module page_frame_allocator_clock_test;
    import pfa_pkg::*;

    localparam int NF = NFRAMES_DEF;
    localparam int WATCHDOG = 4000;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] granted;
        logic               uvalid;
        logic [PAGE_W-1:0]  upage;
        logic               wback;
    } t_result;

    typedef struct packed {
        t_cmd               cmd;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  vpage;
        logic               wr;
        logic               known;
        t_result            res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_command;
    logic [FRAME_W-1:0]   i_frame;
    logic [PAGE_W-1:0]    i_virtual_page;
    logic                 i_is_write;
    logic                 o_done;
    logic [1:0]           o_status;
    logic [FRAME_W-1:0]   o_granted_frame;
    logic                 o_unmapped_valid;
    logic [PAGE_W-1:0]    o_unmapped_page;
    logic                 o_writeback_needed;

    page_frame_allocator_clock dut (.*);

    // frame table copy
    bit              fr_free [NF];
    bit              fr_lock [NF];
    bit              fr_ref  [NF];
    bit              fr_dirty[NF];
    logic [PAGE_W-1:0] fr_page[NF];
    int              free_stk[NF];
    int              stk_cnt;
    int              hand;

    t_result pending_results[$];
    int      errors;
    int      n_sent;
    int      n_done;
    int      idle_cycles;
    int      n_evict;
    int      n_novictim;
    int      idle_pct;
    t_row    dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void table_reset();
        for (int i = 0; i < NF; i++) begin
            fr_free[i] = 1; fr_lock[i] = 0; fr_ref[i] = 0; fr_dirty[i] = 0;
            fr_page[i] = '0;
            free_stk[i] = NF - 1 - i;
        end
        stk_cnt = NF;
        hand = 0;
    endfunction

    function automatic void grant_frame(int f, logic [PAGE_W-1:0] vp);
        fr_free[f] = 0; fr_lock[f] = 1; fr_ref[f] = 0; fr_dirty[f] = 0;
        fr_page[f] = vp;
    endfunction

    function automatic t_result frame_table_step(t_cmd cmd, int f,
                                                 logic [PAGE_W-1:0] vp, bit wr);
        t_result r;
        bit bad;
        bit found;
        int h;
        r = '0;
        r.status = ST_OK;
        bad = fr_free[f];
        case (cmd)
            CMD_ALLOC: begin
                if (stk_cnt > 0) begin
                    stk_cnt--;
                    grant_frame(free_stk[stk_cnt], vp);
                    r.granted = FRAME_W'(free_stk[stk_cnt]);
                end else begin
                    h = hand;
                    found = 0;
                    for (int n = 0; n < 2 * NF; n++) begin
                        if (!fr_lock[h]) begin
                            if (!fr_ref[h]) begin
                                found = 1;
                                break;
                            end
                            fr_ref[h] = 0;
                        end
                        h = (h + 1) % NF;
                    end
                    if (found) begin
                        r.uvalid = 1;
                        r.upage = fr_page[h];
                        r.wback = fr_dirty[h];
                        grant_frame(h, vp);
                        r.granted = FRAME_W'(h);
                        hand = (h + 1) % NF;
                        n_evict++;
                    end else begin
                        r.status = ST_NOVICTIM;
                        n_novictim++;
                    end
                end
            end
            CMD_RELEASE: begin
                if (bad || stk_cnt >= NF) begin
                    r.status = ST_BAD;
                end else begin
                    fr_free[f] = 1; fr_lock[f] = 0; fr_ref[f] = 0; fr_dirty[f] = 0;
                    free_stk[stk_cnt] = f;
                    stk_cnt++;
                    r.uvalid = 1;
                    r.upage = fr_page[f];
                end
            end
            CMD_UNLOCK: begin
                if (bad || !fr_lock[f]) r.status = ST_BAD;
                else fr_lock[f] = 0;
            end
            default: begin
                if (bad) begin
                    r.status = ST_BAD;
                end else begin
                    fr_ref[f] = 1;
                    if (wr) fr_dirty[f] = 1;
                end
            end
        endcase
        return r;
    endfunction

    // one command transfer, then wait for the block to take it
    task automatic issue(t_cmd cmd, logic [FRAME_W-1:0] f, logic [PAGE_W-1:0] vp,
                         logic wr, bit known, t_result kres);
        t_result r;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_frame        <= f;
        i_virtual_page <= vp;
        i_is_write     <= wr;
        do @(posedge i_clk); while (busy);
        r = frame_table_step(cmd, f, vp, wr);
        if (known && r != kres) begin
            errors++;
            if (errors <= 10)
                $display("table row %0d: expected %h, model %h", n_sent, kres, r);
        end
        pending_results.push_back(r);
        n_sent++;
    endtask

    // result check
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && o_done) begin
            got = {o_status, o_granted_frame, o_unmapped_valid, o_unmapped_page,
                   o_writeback_needed};
            n_done++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got != exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected st=%0d fr=%0d uv=%0d up=%h wb=%0d, got st=%0d fr=%0d uv=%0d up=%h wb=%0d",
                                 n_done, exp_r.status, exp_r.granted, exp_r.uvalid,
                                 exp_r.upage, exp_r.wback, got.status, got.granted,
                                 got.uvalid, got.upage, got.wback);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_row mk(t_cmd c, int f, int vp, bit wr, bit known,
                                t_status st, int g, bit uv, int up, bit wb);
        t_row r;
        r.cmd = c; r.frame = FRAME_W'(f); r.vpage = PAGE_W'(vp); r.wr = wr;
        r.known = known;
        r.res = {st, g[FRAME_W-1:0], uv, up[PAGE_W-1:0], wb};
        return r;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * NF + 8) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        t_cmd c;
        int   f;
        int   pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            f = $urandom_range(NF - 1);
            if (pick < 30) c = CMD_ALLOC;
            else if (pick < 45) c = CMD_RELEASE;
            else if (pick < 65) c = CMD_UNLOCK;
            else c = CMD_ACCESS;
            // steer most frame picks toward mapped frames
            if (c != CMD_ALLOC && $urandom_range(9) < 8)
                for (int t = 0; t < 8 && fr_free[f]; t++) f = $urandom_range(NF - 1);
            if (c == CMD_UNLOCK && $urandom_range(3) != 0)
                for (int t = 0; t < 8 && !fr_lock[f]; t++) f = $urandom_range(NF - 1);
            issue(c, FRAME_W'(f), PAGE_W'($urandom_range(16'hffff)),
                  1'($urandom_range(1)), 0, '0);
        end
    endtask

    initial begin
        t_row row;
        errors = 0; n_sent = 0; n_done = 0; idle_cycles = 0;
        n_evict = 0; n_novictim = 0; idle_pct = 0;
        start = 1'b0; i_command = CMD_ALLOC; i_frame = '0;
        i_virtual_page = '0; i_is_write = 1'b0;
        i_rst_n = 1'b0;
        table_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        dir_rows.push_back(mk(CMD_ACCESS, 0, 0, 1, 1, ST_BAD, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_RELEASE, 63, 0, 0, 1, ST_BAD, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_UNLOCK, 5, 0, 0, 1, ST_BAD, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ALLOC, 0, 16'hffff, 0, 1, ST_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ALLOC, 63, 16'h0000, 1, 1, ST_OK, 1, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ACCESS, 1, 0, 1, 1, ST_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_UNLOCK, 1, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_UNLOCK, 1, 0, 0, 1, ST_BAD, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_RELEASE, 0, 0, 0, 1, ST_OK, 0, 1, 16'hffff, 0));
        dir_rows.push_back(mk(CMD_RELEASE, 0, 0, 0, 1, ST_BAD, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ALLOC, 0, 16'h5a5a, 0, 1, ST_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_ACCESS, 63, 0, 0, 1, ST_BAD, 0, 0, 0, 0));
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            issue(row.cmd, row.frame, row.vpage, row.wr, row.known, row.res);
        end
        // drop the unlocked frame, empty the stack, all locked: no victim
        issue(CMD_RELEASE, FRAME_W'(1), '0, 1'b0, 0, '0);
        for (int i = 0; i < NF - 1; i++)
            issue(CMD_ALLOC, '0, PAGE_W'(i + 'h100), 1'b0, 0, '0);
        issue(CMD_ALLOC, 0, 16'h1234, 0, 1, '{ST_NOVICTIM, 0, 0, 0, 0});
        // unlock everything, mark some referenced and dirty, then evict
        for (int i = 0; i < NF; i++) issue(CMD_UNLOCK, FRAME_W'(i), '0, 1'b0, 0, '0);
        for (int i = 0; i < NF; i += 3)
            issue(CMD_ACCESS, FRAME_W'(i), '0, i[0], 0, '0);
        for (int i = 0; i < 6; i++)
            issue(CMD_ALLOC, '0, PAGE_W'($urandom_range(16'hffff)), 1'b0, 0, '0);
        wait_drained();

        // random phases with varied sender idling
        idle_pct = 0;  random_phase(145);
        idle_pct = 72; random_phase(145);
        // sender holds until every result is back
        wait_drained();
        idle_pct = 30; random_phase(145);
        idle_pct = 0;  random_phase(145);

        wait_drained();
        $display("sent %0d commands, %0d results; %0d evictions, %0d no-victim",
                 n_sent, n_done, n_evict, n_novictim);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", errors,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
